@@ rtl/gaabb_pkg.sv @@
package gaabb_pkg;

    localparam int MAT_FRAC = 28;
    localparam int QPROD_W  = 32;
    localparam int MATS_W   = 35;
    localparam int MAG_W    = 33;
    localparam int SCALE_W  = 31;
    localparam int PROD_W   = 63;
    localparam int SUM_W    = 65;
    localparam int RND_W    = 67;
    localparam int EXT_W    = 39;
    localparam int WIDE_W   = 41;
    localparam int STAGES   = 6;

    localparam logic signed [MATS_W-1:0] MAT_ONE   = 35'sh1000_0000;
    localparam logic [RND_W-1:0]         RND_HALF  = 67'h800_0000;
    localparam logic signed [WIDE_W-1:0] SAT_HI    = 41'sh7fff_ffff;
    localparam logic signed [WIDE_W-1:0] SAT_LO    = -41'sh8000_0000;

    typedef struct packed {
        logic [23:0]        item_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        scale_x;
        logic [30:0]        scale_y;
        logic [30:0]        scale_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic [23:0]        out_index;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } out_item_t;

    typedef struct packed {
        logic mul;
        logic sum;
        logic rnd;
    } stage_en_t;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MATS_W-1:0] v);
        logic signed [MATS_W-1:0] n;
        n = -v;
        return v[MATS_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] diag_mag(input logic signed [QPROD_W-1:0] a,
                                                  input logic signed [QPROD_W-1:0] b);
        logic signed [MATS_W-1:0] s;
        s = MAT_ONE - ((MATS_W'(a) + MATS_W'(b)) <<< 1);
        return abs_mag(s);
    endfunction

    function automatic logic [MAG_W-1:0] off_mag(input logic signed [QPROD_W-1:0] a,
                                                 input logic signed [QPROD_W-1:0] b,
                                                 input logic sub);
        logic signed [MATS_W-1:0] s;
        s = sub ? (MATS_W'(a) - MATS_W'(b)) : (MATS_W'(a) + MATS_W'(b));
        s = s <<< 1;
        return abs_mag(s);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[31:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/gaabb_row_proj.sv @@
module gaabb_row_proj (
    input  logic                                    aclk,
    input  gaabb_pkg::stage_en_t                    en,
    input  logic [2:0][gaabb_pkg::MAG_W-1:0]        mag_row,
    input  logic [2:0][gaabb_pkg::SCALE_W-1:0]      scale,
    output logic [gaabb_pkg::EXT_W-1:0]             ext
);
    import gaabb_pkg::*;

    logic [2:0][PROD_W-1:0]  prod_reg, prod_next;
    logic [2:0]              top_reg, top_next;
    logic [2:0][SCALE_W-1:0] scale_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [EXT_W-1:0]        ext_reg, ext_next;
    logic [2:0][PROD_W-1:0]  term;
    logic [RND_W-1:0]        rnd;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = PROD_W'(mag_row[k][MAG_W-2:0]) * PROD_W'(scale[k]);
            top_next[k]  = mag_row[k][MAG_W-1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            term[k] = top_reg[k] ? {scale_reg[k], 32'b0} : prod_reg[k];
        end
        sum_next = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
    end

    always_comb begin
        rnd      = {1'b0, sum_reg, 1'b0} + RND_W'(sum_reg) + RND_HALF;
        ext_next = rnd[RND_W-1:MAT_FRAC];
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_reg  <= prod_next;
            top_reg   <= top_next;
            scale_reg <= scale;
        end
        if (en.sum) begin
            sum_reg <= sum_next;
        end
        if (en.rnd) begin
            ext_reg <= ext_next;
        end
    end

    assign ext = ext_reg;

endmodule

@@ rtl/gaussian_aabb_from_quaternion.sv @@
// channel  direction  ports                       payload
// s_       in         s_valid s_ready s_data      gaabb_pkg::in_item_t
// m_       out        m_valid m_ready m_data      gaabb_pkg::out_item_t
//
// One transfer in and one out per cycle while m_ready is high; a low m_ready stalls the flow.
// Stages: quaternion products, matrix magnitudes, 32x31 multipliers, row
// sums, times three with rounding, saturating box corners.
// Reset clears the stage valid bits only.
// A stalled output holds its stage; earlier stages keep filling up to the
// first occupied one, so bubbles close and nothing is dropped or repeated.
module gaussian_aabb_from_quaternion (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gaabb_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gaabb_pkg::out_item_t  m_data
);
    import gaabb_pkg::*;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES:0]   rdy;

    logic signed [QPROD_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [QPROD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic [2:0][SCALE_W-1:0]   scale1_reg, scale2_reg;
    logic [2:0][2:0][MAG_W-1:0] mag_reg, mag_next;

    logic [STAGES-2:0][2:0][31:0] pos_reg;
    logic [STAGES-2:0][23:0]      idx_reg;

    logic [2:0][EXT_W-1:0]  ext;
    out_item_t              out_reg, out_next;
    stage_en_t              en;

    always_comb begin
        rdy[STAGES] = m_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            xx_reg     <= s_data.quat_x * s_data.quat_x;
            yy_reg     <= s_data.quat_y * s_data.quat_y;
            zz_reg     <= s_data.quat_z * s_data.quat_z;
            xy_reg     <= s_data.quat_x * s_data.quat_y;
            xz_reg     <= s_data.quat_x * s_data.quat_z;
            yz_reg     <= s_data.quat_y * s_data.quat_z;
            wx_reg     <= s_data.quat_w * s_data.quat_x;
            wy_reg     <= s_data.quat_w * s_data.quat_y;
            wz_reg     <= s_data.quat_w * s_data.quat_z;
            scale1_reg <= {s_data.scale_z, s_data.scale_y, s_data.scale_x};
            pos_reg[0] <= {s_data.pos_z, s_data.pos_y, s_data.pos_x};
            idx_reg[0] <= s_data.item_index;
        end
        if (rdy[1]) begin
            mag_reg    <= mag_next;
            scale2_reg <= scale1_reg;
        end
        for (int i = 1; i < STAGES - 1; i++) begin
            if (rdy[i]) begin
                pos_reg[i] <= pos_reg[i-1];
                idx_reg[i] <= idx_reg[i-1];
            end
        end
        if (rdy[STAGES-1]) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        mag_next[0][0] = diag_mag(yy_reg, zz_reg);
        mag_next[0][1] = off_mag(xy_reg, wz_reg, 1'b1);
        mag_next[0][2] = off_mag(xz_reg, wy_reg, 1'b0);
        mag_next[1][0] = off_mag(xy_reg, wz_reg, 1'b0);
        mag_next[1][1] = diag_mag(xx_reg, zz_reg);
        mag_next[1][2] = off_mag(yz_reg, wx_reg, 1'b1);
        mag_next[2][0] = off_mag(xz_reg, wy_reg, 1'b1);
        mag_next[2][1] = off_mag(yz_reg, wx_reg, 1'b0);
        mag_next[2][2] = diag_mag(xx_reg, yy_reg);
    end

    assign en.mul = rdy[2];
    assign en.sum = rdy[3];
    assign en.rnd = rdy[4];

    for (genvar r = 0; r < 3; r++) begin : g_row
        gaabb_row_proj u_row (
            .aclk    (aclk),
            .en      (en),
            .mag_row (mag_reg[r]),
            .scale   (scale2_reg),
            .ext     (ext[r])
        );
    end

    always_comb begin
        logic signed [WIDE_W-1:0] p;
        logic signed [WIDE_W-1:0] e;
        logic [2:0][31:0]         lo;
        logic [2:0][31:0]         hi;
        for (int r = 0; r < 3; r++) begin
            p     = WIDE_W'($signed(pos_reg[STAGES-2][r]));
            e     = $signed({2'b00, ext[r]});
            lo[r] = sat32(p - e);
            hi[r] = sat32(p + e);
        end
        out_next.out_index = idx_reg[STAGES-2];
        out_next.min_x     = lo[0];
        out_next.min_y     = lo[1];
        out_next.min_z     = lo[2];
        out_next.max_x     = hi[0];
        out_next.max_y     = hi[1];
        out_next.max_z     = hi[2];
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[STAGES-1];
    assign m_data  = out_reg;

endmodule

@@ bench/tb_gaussian_aabb_from_quaternion.sv @@
`timescale 1ns / 100ps

module tb_gaussian_aabb_from_quaternion;

    import gaabb_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int ROT_FRAC     = 28;
    localparam int RAND_ITEMS   = 1500;
    localparam int PAUSE_AT     = 400;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;
    localparam int IDLE_PCT     = 24;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        in_item_t  stim;
        logic      typed;
        out_item_t box;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      calm    = 1'b0;

    out_item_t   pending_boxes[$];
    dir_row_t    dir_rows[$];
    int unsigned mismatch_count = 0;

    gaussian_aabb_from_quaternion DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic in_item_t mk_item(
        logic [23:0] idx,
        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
        logic [30:0] sx, logic [30:0] sy, logic [30:0] sz,
        logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw
    );
        in_item_t it;
        it.item_index = idx;
        it.pos_x   = px;
        it.pos_y   = py;
        it.pos_z   = pz;
        it.scale_x = sx;
        it.scale_y = sy;
        it.scale_z = sz;
        it.quat_x  = qx;
        it.quat_y  = qy;
        it.quat_z  = qz;
        it.quat_w  = qw;
        return it;
    endfunction

    function automatic out_item_t mk_box(
        logic [23:0] idx,
        logic [31:0] mnx, logic [31:0] mny, logic [31:0] mnz,
        logic [31:0] mxx, logic [31:0] mxy, logic [31:0] mxz
    );
        out_item_t b;
        b.out_index = idx;
        b.min_x = mnx;
        b.min_y = mny;
        b.min_z = mnz;
        b.max_x = mxx;
        b.max_y = mxy;
        b.max_z = mxz;
        return b;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic out_item_t predict_box(in_item_t it);
        logic signed [63:0] qx, qy, qz, qw, one;
        logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic signed [63:0] rot [3][3];
        logic signed [63:0] ctr [3];
        logic [63:0]        sig3 [3];
        logic [63:0]        mg;
        logic [127:0]       acc;
        logic signed [63:0] half;
        logic signed [31:0] lo_c [3];
        logic signed [31:0] hi_c [3];
        out_item_t          box;
        qx = $signed(it.quat_x);
        qy = $signed(it.quat_y);
        qz = $signed(it.quat_z);
        qw = $signed(it.quat_w);
        ctr[0] = $signed(it.pos_x);
        ctr[1] = $signed(it.pos_y);
        ctr[2] = $signed(it.pos_z);
        sig3[0] = 64'(it.scale_x) * 64'd3;
        sig3[1] = 64'(it.scale_y) * 64'd3;
        sig3[2] = 64'(it.scale_z) * 64'd3;
        one = 64'sd1 <<< ROT_FRAC;
        xx = qx * qx; yy = qy * qy; zz = qz * qz;
        xy = qx * qy; xz = qx * qz; yz = qy * qz;
        wx = qw * qx; wy = qw * qy; wz = qw * qz;
        rot[0][0] = one - 2 * (yy + zz);
        rot[1][0] = 2 * (xy + wz);
        rot[2][0] = 2 * (xz - wy);
        rot[0][1] = 2 * (xy - wz);
        rot[1][1] = one - 2 * (xx + zz);
        rot[2][1] = 2 * (yz + wx);
        rot[0][2] = 2 * (xz + wy);
        rot[1][2] = 2 * (yz - wx);
        rot[2][2] = one - 2 * (xx + yy);
        for (int r = 0; r < 3; r++) begin
            acc = '0;
            for (int c = 0; c < 3; c++) begin
                mg = rot[r][c][63] ? -rot[r][c] : rot[r][c];
                acc += 128'(mg) * 128'(sig3[c]);
            end
            half = $signed(64'((acc + (128'd1 << (ROT_FRAC - 1))) >> ROT_FRAC));
            lo_c[r] = clamp32(ctr[r] - half);
            hi_c[r] = clamp32(ctr[r] + half);
        end
        box.out_index = it.item_index;
        box.min_x = lo_c[0];
        box.min_y = lo_c[1];
        box.min_z = lo_c[2];
        box.max_x = hi_c[0];
        box.max_y = hi_c[1];
        box.max_z = hi_c[2];
        return box;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        it.item_index = 24'($urandom());
        pick = $urandom_range(0, 99);
        it.pos_x = (pick < 80) ? 32'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000)
                               : 32'($urandom());
        it.pos_y = (pick < 80) ? 32'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000)
                               : 32'($urandom());
        it.pos_z = (pick < 80) ? 32'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000)
                               : 32'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            it.scale_x = 31'($urandom_range(0, 32'h0010_0000));
            it.scale_y = 31'($urandom_range(0, 32'h0010_0000));
            it.scale_z = 31'($urandom_range(0, 32'h0010_0000));
        end else if (pick < 90) begin
            it.scale_x = 31'($urandom_range(0, 32'h0100_0000));
            it.scale_y = 31'($urandom_range(0, 32'h0100_0000));
            it.scale_z = 31'($urandom_range(0, 32'h0100_0000));
        end else begin
            it.scale_x = 31'($urandom());
            it.scale_y = 31'($urandom());
            it.scale_z = 31'($urandom());
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            it.quat_x = 16'($urandom_range(0, 32768) - 16384);
            it.quat_y = 16'($urandom_range(0, 32768) - 16384);
            it.quat_z = 16'($urandom_range(0, 32768) - 16384);
            it.quat_w = 16'($urandom_range(0, 32768) - 16384);
        end else if (pick < 92) begin
            it.quat_x = '0;
            it.quat_y = '0;
            it.quat_z = '0;
            it.quat_w = '0;
            case ($urandom_range(0, 3))
                0: it.quat_x = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                1: it.quat_y = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                2: it.quat_z = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                default: it.quat_w = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
            endcase
        end else begin
            it.quat_x = 16'($urandom());
            it.quat_y = 16'($urandom());
            it.quat_z = 16'($urandom());
            it.quat_w = 16'($urandom());
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        int unsigned gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_boxes.push_back(typed ? want : predict_box(it));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : box_monitor
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t ns: unexpected box transfer, expected none, got %h",
                         $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("out_index", 32'(want.out_index), 32'(m_data.out_index));
                check_field("min_x", want.min_x, m_data.min_x);
                check_field("min_y", want.min_y, m_data.min_y);
                check_field("min_z", want.min_z, m_data.min_z);
                check_field("max_x", want.max_x, m_data.max_x);
                check_field("max_y", want.max_y, m_data.max_y);
                check_field("max_z", want.max_z, m_data.max_z);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb_gaussian_aabb_from_quaternion: done, errors");
        $finish;
    end

    initial begin : stimulus
        dir_rows.push_back('{mk_item(24'h000000, 32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0,
                                     16'h0, 16'h0, 16'h0, 16'h4000), 1'b1,
                             mk_box(24'h000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0)});
        dir_rows.push_back('{mk_item(24'hFFFFFF, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                                     31'h1_0000, 31'h8000, 31'h2_0000,
                                     16'h0, 16'h0, 16'h0, 16'h4000), 1'b1,
                             mk_box(24'hFFFFFF, 32'hFFFE_0000, 32'h0000_8000, 32'hFFF7_0000,
                                    32'h0004_0000, 32'h0003_8000, 32'h0003_0000)});
        dir_rows.push_back('{mk_item(24'h000001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                     16'h0, 16'h0, 16'h0, 16'h4000), 1'b1,
                             mk_box(24'h000001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)});
        dir_rows.push_back('{mk_item(24'h000002, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     31'h0, 31'h0, 31'h0,
                                     16'h0, 16'h0, 16'h0, 16'h4000), 1'b1,
                             mk_box(24'h000002, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000)});
        dir_rows.push_back('{mk_item(24'h000003, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     31'h0, 31'h0, 31'h0,
                                     16'h0, 16'h0, 16'h0, 16'h0), 1'b1,
                             mk_box(24'h000003, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)});
        dir_rows.push_back('{mk_item(24'h000004, 32'h0, 32'h0, 32'h0,
                                     31'h1_0000, 31'h1_0000, 31'h1_0000,
                                     16'h0, 16'h0, 16'h0, 16'h0), 1'b1,
                             mk_box(24'h000004, 32'hFFFD_0000, 32'hFFFD_0000, 32'hFFFD_0000,
                                    32'h0003_0000, 32'h0003_0000, 32'h0003_0000)});
        dir_rows.push_back('{mk_item(24'h000005, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                     16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h000006, 32'h0, 32'h0, 32'h0,
                                     31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h000007, 32'h0001_8000, 32'hFFFD_C000, 32'h0,
                                     31'h1_0000, 31'h2_0000, 31'h3_0000,
                                     16'h4000, 16'h0, 16'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h000008, 32'h0, 32'h0, 32'h0,
                                     31'h1_0000, 31'h4_0000, 31'h1_0000,
                                     16'h0, 16'h0, 16'h2D41, 16'h2D41), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h000009, 32'h0, 32'h0, 32'h0,
                                     31'h1_0000, 31'h1_0000, 31'h1_0000,
                                     16'h4000, 16'h4000, 16'h4000, 16'h4000), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h00000A, 32'h0, 32'h0, 32'h0, 31'h1, 31'h1, 31'h1,
                                     16'h2000, 16'h0, 16'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h00000B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     31'h1, 31'h3, 31'h5,
                                     16'h2000, 16'h0, 16'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h00000C, 32'h1234_5678, 32'hEDCB_A988, 32'h0,
                                     31'h2AAA_AAAA, 31'h5555_5555, 31'h0001_2345,
                                     16'h0, 16'hC000, 16'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h00000D, 32'h0, 32'h0, 32'h0,
                                     31'h1_0000, 31'h1_0000, 31'h1_0000,
                                     16'h0, 16'h0, 16'h0, 16'h8000), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h00000E, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     31'h1_0000, 31'h1_0000, 31'h1_0000,
                                     16'h0, 16'h0, 16'h0, 16'h4000), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'hAAAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                                     31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF,
                                     16'h1000, 16'hE000, 16'h3000, 16'hF000), 1'b0, '0});
        dir_rows.push_back('{mk_item(24'h555555, 32'h0000_FFFF, 32'hFFFF_0000, 32'h8000_0001,
                                     31'h0000_FFFF, 31'h7FFF_0000, 31'h0,
                                     16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b0, '0});

        while (!aresetn) @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].box);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_boxes.size() != 0) @(posedge aclk);
            end
            if (n == CALM_FROM) begin
                calm <= 1'b1;
            end
            if (n == CALM_TO) begin
                calm <= 1'b0;
            end
            send_item(random_item(), 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_gaussian_aabb_from_quaternion: done, clean");
        end else begin
            $display("tb_gaussian_aabb_from_quaternion: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/gaabb_pkg.sv
rtl/gaabb_row_proj.sv
rtl/gaussian_aabb_from_quaternion.sv
bench/tb_gaussian_aabb_from_quaternion.sv
